### design/cawf_pkg.sv
// Shared types, operation codes and helpers for the accumulator ALU with flags.
// Depends on nothing; every other design file uses it.
package cawf_pkg;

  localparam int unsigned KIND_W = 5;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned PAIR_W = 16;

  // Operation codes; codes above OP_LOADP change nothing.
  typedef enum logic [KIND_W-1:0] {
    OP_ADD   = 5'd0,
    OP_ADC   = 5'd1,
    OP_SUB   = 5'd2,
    OP_SBB   = 5'd3,
    OP_AND   = 5'd4,
    OP_XOR   = 5'd5,
    OP_OR    = 5'd6,
    OP_CMP   = 5'd7,
    OP_INC   = 5'd8,
    OP_DEC   = 5'd9,
    OP_RLC   = 5'd10,
    OP_RRC   = 5'd11,
    OP_RAL   = 5'd12,
    OP_RAR   = 5'd13,
    OP_CMA   = 5'd14,
    OP_STC   = 5'd15,
    OP_CMC   = 5'd16,
    OP_DAD   = 5'd17,
    OP_LOADA = 5'd18,
    OP_LOADP = 5'd19
  } kind_t;

  // Architectural state of the ALU.
  typedef struct packed {
    logic [BYTE_W-1:0] acc;
    logic [PAIR_W-1:0] pair;
    logic              carry;
    logic              zero;
    logic              sign;
    logic              parity;
  } alu_state_t;

  // Even parity: 1 when the byte holds an even number of ones.
  function automatic logic even_parity(input logic [BYTE_W-1:0] v);
    return ~(^v);
  endfunction

endpackage

### design/cawf_if.sv
// Handshake channels of the ALU: the request channel and the result channel.
// Depends on cawf_pkg for field widths.
interface cawf_req_if;
  logic                         valid;
  logic                         ready;
  logic [cawf_pkg::KIND_W-1:0]  kind;
  logic [cawf_pkg::PAIR_W-1:0]  operand;

  modport source (output valid, output kind, output operand, input ready);
  modport sink   (input valid, input kind, input operand, output ready);
endinterface

interface cawf_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [cawf_pkg::BYTE_W-1:0]  accumulator_out;
  logic [cawf_pkg::PAIR_W-1:0]  pair_out;
  logic [cawf_pkg::BYTE_W-1:0]  result_byte;
  logic                         zero_flag;
  logic                         sign_flag;
  logic                         parity_flag;
  logic                         carry_out;

  modport source (output valid, output accumulator_out, output pair_out, output result_byte,
                  output zero_flag, output sign_flag, output parity_flag, output carry_out,
                  input ready);
  modport sink   (input valid, input accumulator_out, input pair_out, input result_byte,
                  input zero_flag, input sign_flag, input parity_flag, input carry_out,
                  output ready);
endinterface

### design/cawf_exec.sv
// Combinational execute unit: applies one operation to the ALU state.
// Depends on cawf_pkg for the state type, operation codes and parity helper.
module cawf_exec (
  input  cawf_pkg::alu_state_t            st,
  input  logic [cawf_pkg::KIND_W-1:0]     kind,
  input  logic [cawf_pkg::PAIR_W-1:0]     operand,
  output cawf_pkg::alu_state_t            st_next,
  output logic [cawf_pkg::BYTE_W-1:0]     res_byte
);
  import cawf_pkg::*;

  logic [BYTE_W-1:0] b;
  logic              cin;
  logic [BYTE_W:0]   sum9;
  logic [BYTE_W:0]   diff9;
  logic [PAIR_W:0]   pair_sum;

  assign b = operand[BYTE_W-1:0];

  // Carry or borrow in only for the with-carry forms.
  assign cin = ((kind == OP_ADC) || (kind == OP_SBB)) ? st.carry : 1'b0;

  // Shared byte adder and subtractor; bit 8 is the carry or the borrow.
  assign sum9  = {1'b0, st.acc} + {1'b0, b} + {{BYTE_W{1'b0}}, cin};
  assign diff9 = {1'b0, st.acc} - {1'b0, b} - {{BYTE_W{1'b0}}, cin};

  // Sixteen-bit pair adder.
  assign pair_sum = {1'b0, st.pair} + {1'b0, operand};

  // Operation decoder.
  always_comb begin
    st_next  = st;
    res_byte = st.acc;
    unique case (kind)
      OP_ADD, OP_ADC: begin
        res_byte       = sum9[BYTE_W-1:0];
        st_next.acc    = sum9[BYTE_W-1:0];
        st_next.carry  = sum9[BYTE_W];
      end
      OP_SUB, OP_SBB: begin
        res_byte       = diff9[BYTE_W-1:0];
        st_next.acc    = diff9[BYTE_W-1:0];
        st_next.carry  = diff9[BYTE_W];
      end
      OP_AND: begin
        res_byte       = st.acc & b;
        st_next.acc    = st.acc & b;
        st_next.carry  = 1'b0;
      end
      OP_XOR: begin
        res_byte       = st.acc ^ b;
        st_next.acc    = st.acc ^ b;
        st_next.carry  = 1'b0;
      end
      OP_OR: begin
        res_byte       = st.acc | b;
        st_next.acc    = st.acc | b;
        st_next.carry  = 1'b0;
      end
      OP_CMP: begin
        res_byte       = diff9[BYTE_W-1:0];
        st_next.carry  = diff9[BYTE_W];
      end
      OP_INC: res_byte = b + 8'd1;
      OP_DEC: res_byte = b - 8'd1;
      OP_RLC: begin
        st_next.acc    = {st.acc[BYTE_W-2:0], st.acc[BYTE_W-1]};
        st_next.carry  = st.acc[BYTE_W-1];
        res_byte       = {st.acc[BYTE_W-2:0], st.acc[BYTE_W-1]};
      end
      OP_RRC: begin
        st_next.acc    = {st.acc[0], st.acc[BYTE_W-1:1]};
        st_next.carry  = st.acc[0];
        res_byte       = {st.acc[0], st.acc[BYTE_W-1:1]};
      end
      OP_RAL: begin
        st_next.acc    = {st.acc[BYTE_W-2:0], st.carry};
        st_next.carry  = st.acc[BYTE_W-1];
        res_byte       = {st.acc[BYTE_W-2:0], st.carry};
      end
      OP_RAR: begin
        st_next.acc    = {st.carry, st.acc[BYTE_W-1:1]};
        st_next.carry  = st.acc[0];
        res_byte       = {st.carry, st.acc[BYTE_W-1:1]};
      end
      OP_CMA: begin
        st_next.acc    = ~st.acc;
        res_byte       = ~st.acc;
      end
      OP_STC: st_next.carry = 1'b1;
      OP_CMC: st_next.carry = ~st.carry;
      OP_DAD: begin
        st_next.pair   = pair_sum[PAIR_W-1:0];
        st_next.carry  = pair_sum[PAIR_W];
      end
      OP_LOADA: begin
        st_next.acc    = b;
        res_byte       = b;
      end
      OP_LOADP: st_next.pair = operand;
      default: ;
    endcase

    // Zero, sign and parity follow the byte result of the operations that set them.
    case (kind)
      OP_ADD, OP_ADC, OP_SUB, OP_SBB, OP_AND, OP_XOR, OP_OR, OP_CMP, OP_INC, OP_DEC: begin
        st_next.zero   = (res_byte == '0);
        st_next.sign   = res_byte[BYTE_W-1];
        st_next.parity = even_parity(res_byte);
      end
      default: ;
    endcase
  end

endmodule

### design/cpu_alu_with_flags_top.sv
// Top level of the accumulator ALU with flags: input register, execute, result register.
// Depends on cawf_pkg, the channel interfaces in cawf_if.sv and cawf_exec.
// Usage:
//   req carries one operation (kind) and a 16-bit operand; a request is taken
//   on a clock edge where req.valid and req.ready are both high.
//   rsp carries the accumulator, register pair, byte result and the four flags
//   as they stand after that operation; it is taken when rsp.valid and
//   rsp.ready are both high. Every request gives exactly one result, in order.
// Pipeline and throughput:
//   A request is registered, executed against the architectural state as it
//   leaves the input register, and its result is captured in the result register.
//   One request per cycle is sustained while rsp.ready is high; the state
//   registers feed the execute logic directly, so back-to-back operations
//   see each other's effects.
// Reset:
//   rst (synchronous, active high) clears the accumulator, pair and all flags
//   and empties both pipeline registers.
// Stalls:
//   When rsp.ready is low with a result held, the input register keeps its
//   request and req.ready drops once that register is also full; no request
//   is lost or repeated.
module cpu_alu_with_flags_top (
  input  logic       clk,
  input  logic       rst,
  cawf_req_if.sink   req,
  cawf_rsp_if.source rsp
);
  import cawf_pkg::*;

  logic                 in_valid;
  logic [KIND_W-1:0]    in_kind;
  logic [PAIR_W-1:0]    in_operand;
  alu_state_t           state;
  alu_state_t           state_next;
  logic [BYTE_W-1:0]    res_byte;
  logic                 out_free;
  logic                 advance;

  // Flow control: the input register moves when the result register can take it.
  assign out_free  = ~rsp.valid | rsp.ready;
  assign advance   = in_valid & out_free;
  assign req.ready = ~in_valid | out_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
    if (req.valid && req.ready) begin
      in_kind    <= req.kind;
      in_operand <= req.operand;
    end
  end

  // Execute unit.
  cawf_exec u_exec (
    .st       (state),
    .kind     (in_kind),
    .operand  (in_operand),
    .st_next  (state_next),
    .res_byte (res_byte)
  );

  // Architectural state updates as each request leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_free) begin
      rsp.valid <= in_valid;
    end
    if (advance) begin
      rsp.accumulator_out <= state_next.acc;
      rsp.pair_out        <= state_next.pair;
      rsp.result_byte     <= res_byte;
      rsp.zero_flag       <= state_next.zero;
      rsp.sign_flag       <= state_next.sign;
      rsp.parity_flag     <= state_next.parity;
      rsp.carry_out       <= state_next.carry;
    end
  end

endmodule
